// ===== design/assert_macros.svh =====
// Assertion helpers, empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== design/ntrc_pkg.sv =====
package ntrc_pkg;

  localparam int CLOCK_HZ  = 90000;
  localparam int WINDOW_MS = 100;
  localparam int MS_PER_S  = 1000;
  localparam logic [32:0] WINDOW_RESET = 33'(CLOCK_HZ * WINDOW_MS / MS_PER_S);

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_TAKE  = 1'b1;

  localparam logic [2:0] STATUS_NEW     = 3'd0;
  localparam logic [2:0] STATUS_REPLACE = 3'd1;
  localparam logic [2:0] STATUS_IGNORED = 3'd2;
  localparam logic [2:0] STATUS_FULL    = 3'd3;
  localparam logic [2:0] STATUS_TAKEN   = 3'd4;
  localparam logic [2:0] STATUS_NOMATCH = 3'd5;

  localparam logic [4:0] PURGE_MAX = 5'd31;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] key;
    logic signed [33:0] stamp;
    logic [47:0]        now;
  } query_t;

  typedef struct packed {
    logic        valid;
    logic [4:0]  purged;
    logic        best_hit;
    logic [32:0] best_dist;
    logic        id_hit;
    logic        free_hit;
  } token_t;

  typedef struct packed {
    logic signed [31:0] id;
    logic signed [33:0] stamp;
    logic [47:0]        expire;
    logic [31:0]        payload;
  } entry_t;

  typedef struct packed {
    logic   en;
    logic   clear;
    entry_t data;
  } commit_t;

endpackage

// ===== design/ntrc_cell.sv =====
module ntrc_cell #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  ntrc_pkg::query_t    query,
  input  logic [32:0]         match_window,
  input  ntrc_pkg::commit_t   commit,
  input  logic [IDX_W-1:0]    commit_idx,
  input  ntrc_pkg::token_t    tok_in,
  input  logic [IDX_W-1:0]    best_idx_in,
  input  logic [IDX_W-1:0]    id_idx_in,
  input  logic [IDX_W-1:0]    free_idx_in,
  output ntrc_pkg::token_t    tok_out,
  output logic [IDX_W-1:0]    best_idx_out,
  output logic [IDX_W-1:0]    id_idx_out,
  output logic [IDX_W-1:0]    free_idx_out,
  output ntrc_pkg::entry_t    entry
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic               valid;
  logic               expired;
  logic               valid_eff;
  logic               id_match;
  logic signed [34:0] diff;
  logic [34:0]        mag;
  logic [32:0]        span;
  logic               stamp_cand;
  logic               mine;
  ntrc_pkg::token_t   tok_next;

  assign mine      = commit.en && (commit_idx == MyIdx);
  assign expired   = valid && (query.mode == ntrc_pkg::MODE_TAKE) &&
                     (entry.expire < query.now);
  assign valid_eff = valid && !expired;
  assign id_match  = valid_eff && (entry.id == query.key);

  assign diff = {entry.stamp[33], entry.stamp} - {query.stamp[33], query.stamp};
  assign mag  = diff[34] ? 35'(-diff) : 35'(diff);
  assign span = mag[32:0];

  assign stamp_cand = (query.mode == ntrc_pkg::MODE_TAKE) && valid_eff &&
                      !query.stamp[33] && !entry.stamp[33] &&
                      (span <= match_window) &&
                      (!tok_in.best_hit || (span < tok_in.best_dist));

  always_comb begin
    tok_next = tok_in;
    if (expired && (tok_in.purged != ntrc_pkg::PURGE_MAX)) begin
      tok_next.purged = tok_in.purged + 5'd1;
    end
    if (stamp_cand) begin
      tok_next.best_hit  = 1'b1;
      tok_next.best_dist = span;
    end
    if (id_match) begin
      tok_next.id_hit = 1'b1;
    end
    if (!valid) begin
      tok_next.free_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_in.valid ? tok_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_out <= stamp_cand ? MyIdx : best_idx_in;
    id_idx_out   <= (id_match && !tok_in.id_hit) ? MyIdx : id_idx_in;
    free_idx_out <= (!valid && !tok_in.free_hit) ? MyIdx : free_idx_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (mine) begin
      valid <= !commit.clear;
    end else if (tok_in.valid && expired) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mine && !commit.clear) begin
      entry <= commit.data;
    end
  end

endmodule

// ===== design/nearest_timestamp_result_cache.sv =====
// Result cache of TABLE_DEPTH entries held in a row of cells. Each item runs
// one token down the row, one cell per cycle, which for a take purges expired
// entries and records the nearest-stamp, id and free-slot candidates; the
// finish state, once the output is free, writes or removes the chosen entry
// and loads the result. An item passes from the start register through the
// cell row to the finish state; one item is in work at a time, and the next
// item is accepted while a result waits at the output. match_window is written
// through cfg_wen / cfg_wdata and resets to 9000 ticks.
`include "assert_macros.svh"

module nearest_timestamp_result_cache #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wen,
  input  logic [32:0]   cfg_wdata,   // match_window
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [199:0]  s_tdata,     // key_id, stamp, expire_ms, now_ms, payload
  input  logic [0:0]    s_tuser,     // mode
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [151:0]  m_tdata,     // out_id, out_stamp, out_expire, out_payload,
                                     // purged_count
  output logic [3:0]    m_tuser      // status, by_stamp
);

  localparam int IdxW = $clog2(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]          state;
  logic [32:0]         match_window;
  logic                start;
  ntrc_pkg::query_t    query;
  logic [47:0]         q_expire;
  logic [31:0]         q_payload;

  ntrc_pkg::token_t    tok_w  [TABLE_DEPTH+1];
  logic [IdxW-1:0]     best_w [TABLE_DEPTH+1];
  logic [IdxW-1:0]     id_w   [TABLE_DEPTH+1];
  logic [IdxW-1:0]     free_w [TABLE_DEPTH+1];
  ntrc_pkg::entry_t    ent    [TABLE_DEPTH];

  ntrc_pkg::token_t    fin;
  logic [IdxW-1:0]     fin_best;
  logic [IdxW-1:0]     fin_id;
  logic [IdxW-1:0]     fin_free;

  ntrc_pkg::commit_t   commit;
  logic [IdxW-1:0]     sel_idx;
  logic [2:0]          status_next;
  logic                by_stamp_next;
  logic                out_free;
  logic                finish_go;
  logic                accept;

  logic [2:0]          status;
  logic                by_stamp;
  ntrc_pkg::entry_t    out_entry;
  logic [4:0]          purged;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign finish_go = (state == ST_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_window <= ntrc_pkg::WINDOW_RESET;
    end else if (cfg_wen) begin
      match_window <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query.mode  <= s_tuser[0];
      query.key   <= s_tdata[31:0];
      query.stamp <= s_tdata[65:32];
      query.now   <= s_tdata[161:114];
      q_expire    <= s_tdata[113:66];
      q_payload   <= s_tdata[193:162];
    end
  end

  always_comb begin
    tok_w[0]       = '0;
    tok_w[0].valid = start;
    best_w[0]      = '0;
    id_w[0]        = '0;
    free_w[0]      = '0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ntrc_cell #(
      .CELL_IDX (i),
      .IDX_W    (IdxW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .query        (query),
      .match_window (match_window),
      .commit       (commit),
      .commit_idx   (sel_idx),
      .tok_in       (tok_w[i]),
      .best_idx_in  (best_w[i]),
      .id_idx_in    (id_w[i]),
      .free_idx_in  (free_w[i]),
      .tok_out      (tok_w[i+1]),
      .best_idx_out (best_w[i+1]),
      .id_idx_out   (id_w[i+1]),
      .free_idx_out (free_w[i+1]),
      .entry        (ent[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      start <= 1'b0;
    end else begin
      start <= accept;
      unique case (state)
        ST_IDLE: begin
          if (accept) state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (tok_w[TABLE_DEPTH].valid) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tok_w[TABLE_DEPTH].valid) begin
      fin      <= tok_w[TABLE_DEPTH];
      fin_best <= best_w[TABLE_DEPTH];
      fin_id   <= id_w[TABLE_DEPTH];
      fin_free <= free_w[TABLE_DEPTH];
    end
  end

  always_comb begin
    status_next   = ntrc_pkg::STATUS_NOMATCH;
    by_stamp_next = 1'b0;
    sel_idx       = fin_id;
    if (query.mode == ntrc_pkg::MODE_STORE) begin
      priority if (query.key[31]) begin
        status_next = ntrc_pkg::STATUS_IGNORED;
      end else if (fin.id_hit) begin
        status_next = ntrc_pkg::STATUS_REPLACE;
      end else if (fin.free_hit) begin
        status_next = ntrc_pkg::STATUS_NEW;
        sel_idx     = fin_free;
      end else begin
        status_next = ntrc_pkg::STATUS_FULL;
      end
    end else begin
      priority if (fin.best_hit) begin
        status_next   = ntrc_pkg::STATUS_TAKEN;
        by_stamp_next = 1'b1;
        sel_idx       = fin_best;
      end else if (!query.key[31] && fin.id_hit) begin
        status_next = ntrc_pkg::STATUS_TAKEN;
      end else begin
        status_next = ntrc_pkg::STATUS_NOMATCH;
      end
    end
  end

  always_comb begin
    commit.en           = finish_go &&
                          ((status_next == ntrc_pkg::STATUS_NEW) ||
                           (status_next == ntrc_pkg::STATUS_REPLACE) ||
                           (status_next == ntrc_pkg::STATUS_TAKEN));
    commit.clear        = (query.mode == ntrc_pkg::MODE_TAKE);
    commit.data.id      = query.key;
    commit.data.stamp   = query.stamp;
    commit.data.expire  = q_expire;
    commit.data.payload = q_payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      status    <= status_next;
      by_stamp  <= by_stamp_next;
      out_entry <= (status_next == ntrc_pkg::STATUS_TAKEN) ? ent[sel_idx] : '0;
      purged    <= (query.mode == ntrc_pkg::MODE_TAKE) ? fin.purged : 5'd0;
    end
  end

  assign m_tdata = {1'b0, purged, out_entry.payload, out_entry.expire,
                    out_entry.stamp, out_entry.id};
  assign m_tuser = {by_stamp, status};

  `ASSERT_PROP(a_accept_sweep, clk, rst, accept |=> (state == ST_SWEEP))
  `ASSERT_PROP(a_token_in_sweep, clk, rst, tok_w[TABLE_DEPTH].valid |-> (state == ST_SWEEP))
  `ASSERT_PROP(a_finish_loads, clk, rst, finish_go |=> (m_tvalid && (state == ST_IDLE)))
  `ASSERT_NEVER(a_status_range, clk, rst, m_tvalid && (status > ntrc_pkg::STATUS_NOMATCH))

endmodule

// ===== verif/tb_nearest_timestamp_result_cache.sv =====
module tb_nearest_timestamp_result_cache;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int PEND_SLOTS = 64;
  localparam logic [32:0] WINDOW_MAX = 33'h1_FFFF_FFFF;
  localparam logic [47:0] MS_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [33:0] STAMP_MAX = 34'sh1_FFFF_FFFF;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NO_KEY = -32'sd1;
  localparam logic signed [33:0] NO_STAMP = -34'sd1;

  typedef struct {
    logic               mode;
    logic signed [31:0] key;
    logic signed [33:0] stamp;
    logic [47:0]        expire;
    logic [47:0]        now;
    logic [31:0]        payload;
  } cache_item_t;

  typedef struct {
    logic [2:0]  status;
    logic        by_stamp;
    logic [31:0] id;
    logic [33:0] stamp;
    logic [47:0] expire;
    logic [31:0] payload;
    logic [4:0]  purged;
  } cache_result_t;

  logic          clk;
  logic          rst = 1'b1;
  logic          cfg_wen = 1'b0;
  logic [32:0]   cfg_wdata = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [199:0]  s_tdata = '0;     // key_id, stamp, expire_ms, now_ms, payload
  logic [0:0]    s_tuser = '0;     // mode
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [151:0]  m_tdata;          // out_id, out_stamp, out_expire, out_payload,
                                   // purged_count
  logic [3:0]    m_tuser;          // status, by_stamp

  // mirror of the cache
  logic               slot_valid [DEPTH];
  logic signed [31:0] slot_id [DEPTH];
  logic signed [33:0] slot_stamp [DEPTH];
  logic [47:0]        slot_expire [DEPTH];
  logic [31:0]        slot_payload [DEPTH];
  logic [32:0]        window_ticks = ntrc_pkg::WINDOW_RESET;

  cache_result_t pending_results [PEND_SLOTS];
  int            pend_wr = 0;
  int            pend_rd = 0;
  int            fail_count = 0;
  bit            tx_steady = 1'b0;
  bit            rx_steady = 1'b0;
  int            rx_hold_req = 0;
  logic [47:0]   clock_ms = '0;

  nearest_timestamp_result_cache #(.TABLE_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic cache_result_t apply_to_cache(cache_item_t it);
    cache_result_t r;
    int hit;
    int free_slot;
    longint delta;
    longint best;
    r = '{default: '0};
    hit = -1;
    free_slot = -1;
    best = 0;
    if (it.mode == ntrc_pkg::MODE_STORE) begin
      if (it.key < 0) begin
        r.status = ntrc_pkg::STATUS_IGNORED;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_valid[i] && slot_id[i] == it.key && hit < 0) hit = i;
          if (!slot_valid[i] && free_slot < 0) free_slot = i;
        end
        if (hit >= 0) begin
          r.status = ntrc_pkg::STATUS_REPLACE;
        end else if (free_slot >= 0) begin
          r.status = ntrc_pkg::STATUS_NEW;
          hit = free_slot;
        end else begin
          r.status = ntrc_pkg::STATUS_FULL;
        end
        if (hit >= 0) begin
          slot_valid[hit] = 1'b1;
          slot_id[hit] = it.key;
          slot_stamp[hit] = it.stamp;
          slot_expire[hit] = it.expire;
          slot_payload[hit] = it.payload;
        end
      end
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_valid[i] && slot_expire[i] < it.now) begin
          slot_valid[i] = 1'b0;
          if (r.purged < ntrc_pkg::PURGE_MAX) r.purged = r.purged + 5'd1;
        end
      end
      if (it.stamp >= 0) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_valid[i] && slot_stamp[i] >= 0) begin
            delta = longint'(slot_stamp[i]) - longint'(it.stamp);
            if (delta < 0) delta = -delta;
            if (delta <= longint'({31'b0, window_ticks}) && (hit < 0 || delta < best)) begin
              hit = i;
              best = delta;
            end
          end
        end
        if (hit >= 0) r.by_stamp = 1'b1;
      end
      if (hit < 0 && it.key >= 0) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (hit < 0 && slot_valid[i] && slot_id[i] == it.key) hit = i;
        end
      end
      if (hit >= 0) begin
        r.status = ntrc_pkg::STATUS_TAKEN;
        r.id = slot_id[hit];
        r.stamp = slot_stamp[hit];
        r.expire = slot_expire[hit];
        r.payload = slot_payload[hit];
        slot_valid[hit] = 1'b0;
      end else begin
        r.status = ntrc_pkg::STATUS_NOMATCH;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic cache_item_t mk(logic mode, logic signed [31:0] key,
                                     logic signed [33:0] stamp, logic [47:0] expire,
                                     logic [47:0] now, logic [31:0] payload);
    cache_item_t it;
    it.mode = mode;
    it.key = key;
    it.stamp = stamp;
    it.expire = expire;
    it.now = now;
    it.payload = payload;
    return it;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    cache_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pend_wr == pend_rd) begin
        $error("result with no item pending");
        fail_count++;
      end else begin
        want = pending_results[pend_rd % PEND_SLOTS];
        pend_rd++;
        compare_field("status", 64'(want.status), 64'(m_tuser[2:0]));
        compare_field("by_stamp", 64'(want.by_stamp), 64'(m_tuser[3]));
        compare_field("out_id", 64'(want.id), 64'(m_tdata[31:0]));
        compare_field("out_stamp", 64'(want.stamp), 64'(m_tdata[65:32]));
        compare_field("out_expire", 64'(want.expire), 64'(m_tdata[113:66]));
        compare_field("out_payload", 64'(want.payload), 64'(m_tdata[145:114]));
        compare_field("purged_count", 64'(want.purged), 64'(m_tdata[150:146]));
      end
    end
  end

  // receiver: random ready/stall runs, long hold on request
  initial begin : result_sink
    int n;
    @(negedge rst);
    forever begin
      if (rx_hold_req > 0) begin
        n = rx_hold_req;
        rx_hold_req = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        n = pick_gap();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(input cache_item_t it);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, it.payload, it.now, it.expire, it.stamp, it.key};
    s_tuser <= it.mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results[pend_wr % PEND_SLOTS] = apply_to_cache(it);
    pend_wr++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_window(input logic [32:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    window_ticks = value;
  endtask

  task automatic test_basic_ops();
    send_item(mk(ntrc_pkg::MODE_TAKE, NO_KEY, NO_STAMP, '0, '0, '0));
    send_item(mk(ntrc_pkg::MODE_STORE, NO_KEY, 34'sd10, MS_MAX, '0, 32'h1));
    send_item(mk(ntrc_pkg::MODE_STORE, 32'sd0, 34'sd0, MS_MAX, '0, 32'h0));
    send_item(mk(ntrc_pkg::MODE_STORE, KEY_MAX, STAMP_MAX, MS_MAX, MS_MAX, 32'hFFFF_FFFF));
    send_item(mk(ntrc_pkg::MODE_STORE, 32'sd0, 34'sd100, MS_MAX, '0, 32'h1234));
    send_item(mk(ntrc_pkg::MODE_STORE, 32'sd5, NO_STAMP, 48'd1000, '0, 32'h55));
    // window edge: distance equals the window
    send_item(mk(ntrc_pkg::MODE_TAKE, NO_KEY, 34'sd9100, '0, '0, '0));
    // entry without stamp found by id; expiry equal to now keeps it
    send_item(mk(ntrc_pkg::MODE_TAKE, 32'sd5, 34'sd50, '0, 48'd1000, '0));
    send_item(mk(ntrc_pkg::MODE_STORE, 32'sd7, 34'sd500, 48'd10, '0, 32'h77));
    send_item(mk(ntrc_pkg::MODE_STORE, 32'sd8, 34'sd500, 48'd20, '0, 32'h88));
    // tie goes to the lower slot
    send_item(mk(ntrc_pkg::MODE_TAKE, NO_KEY, 34'sd500, '0, 48'd10, '0));
    // absent stamp, expired id
    send_item(mk(ntrc_pkg::MODE_TAKE, 32'sd8, NO_STAMP, '0, 48'd21, '0));
    send_item(mk(ntrc_pkg::MODE_TAKE, KEY_MAX, NO_STAMP, '0, MS_MAX, '0));
    drain();
  endtask

  task automatic test_window_extremes();
    write_window('0);
    send_item(mk(ntrc_pkg::MODE_STORE, 32'sd1, 34'sd1000, MS_MAX, '0, 32'hA5A5_A5A5));
    send_item(mk(ntrc_pkg::MODE_TAKE, NO_KEY, 34'sd1001, '0, '0, '0));
    send_item(mk(ntrc_pkg::MODE_TAKE, NO_KEY, 34'sd1000, '0, '0, '0));
    drain();
    write_window(WINDOW_MAX);
    send_item(mk(ntrc_pkg::MODE_STORE, 32'sd2, 34'sd0, MS_MAX, '0, 32'h5A5A_5A5A));
    send_item(mk(ntrc_pkg::MODE_TAKE, NO_KEY, STAMP_MAX, '0, '0, '0));
    drain();
    write_window(ntrc_pkg::WINDOW_RESET);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < DEPTH; i++)
      send_item(mk(ntrc_pkg::MODE_STORE, 32'(300 + i), 34'(i * 20000),
                   48'($urandom_range(0, 1000)), '0, $urandom()));
    send_item(mk(ntrc_pkg::MODE_STORE, 32'sd400, 34'sd5, MS_MAX, '0, 32'h400));
    send_item(mk(ntrc_pkg::MODE_STORE, 32'sd300, 34'sd7, 48'd3, '0, 32'h300));
    // purges every entry at once
    send_item(mk(ntrc_pkg::MODE_TAKE, NO_KEY, NO_STAMP, '0, MS_MAX, '0));
    drain();
  endtask

  function automatic cache_item_t random_item(longint base);
    cache_item_t it;
    int r;
    it.mode = ($urandom_range(0, 99) < 55) ? ntrc_pkg::MODE_STORE : ntrc_pkg::MODE_TAKE;
    r = $urandom_range(0, 99);
    if (r < 6) it.key = NO_KEY;
    else if (r < 10) it.key = {1'b0, 31'($urandom())};
    else it.key = 32'($urandom_range(0, 23));
    r = $urandom_range(0, 99);
    if (r < 6) it.stamp = NO_STAMP;
    else if (r < 10) it.stamp = {1'b0, 33'({$urandom(), $urandom()})};
    else it.stamp = 34'(base + longint'($urandom_range(0, 40000)));
    r = $urandom_range(0, 99);
    if (r < 3) it.expire = '0;
    else if (r < 6) it.expire = MS_MAX;
    else if (r < 9) it.expire = 48'({$urandom(), $urandom()});
    else it.expire = clock_ms + 48'($urandom_range(0, 3000));
    r = $urandom_range(0, 99);
    if (r < 2) it.now = 48'({$urandom(), $urandom()});
    else if (r < 4) it.now = MS_MAX;
    else if (r < 6) it.now = '0;
    else it.now = clock_ms;
    clock_ms = clock_ms + 48'($urandom_range(0, 40));
    it.payload = $urandom();
    return it;
  endfunction

  task automatic test_random_traffic();
    longint base;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_window('0);
        1: write_window(WINDOW_MAX);
        2: write_window(ntrc_pkg::WINDOW_RESET);
        4: write_window(33'({$urandom(), $urandom()}));
        default: write_window(33'($urandom_range(0, 20000)));
      endcase
      case (ph % 3)
        0: base = 0;
        1: base = longint'(WINDOW_MAX) - 40000;
        default: base = longint'($urandom());
      endcase
      tx_steady = (ph == 2) || (ph == 5);
      rx_steady = (ph == 2) || (ph == 6);
      for (int n = 0; n < 100; n++) send_item(random_item(base));
      drain();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_output_stall();
    rx_hold_req = 300;
    tx_steady = 1'b1;
    for (int n = 0; n < 12; n++) send_item(random_item(0));
    tx_steady = 1'b0;
    drain();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) slot_valid[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_window_extremes();
    test_table_full();
    test_random_traffic();
    test_output_stall();
    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
